@@ design/breakpoint_envelope_table_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the breakpoint envelope table
// Shared check forms, clocked on clk and quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_ENVELOPE_TABLE_UNIT_MACROS_SVH
`define BREAKPOINT_ENVELOPE_TABLE_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define BET_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define BET_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bet_pkg.sv @@
// ----------------------------------------------------------------------------
// bet_pkg
// Types, codes and command/status structures of the breakpoint envelope table
// ----------------------------------------------------------------------------
`default_nettype none

package bet_pkg;

    localparam int FuncW    = 2;
    localparam int IdxW     = 5;
    localparam int CoordW   = 16;
    localparam int GapW     = 15;
    localparam int StatW    = 2;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 16;
    localparam int LockW    = 4;
    localparam int DvdW     = 33;
    localparam int DivSteps = DvdW;
    localparam int DcntW    = 6;

    // request function codes
    typedef enum logic [FuncW-1:0] {
        FN_EVAL = 2'd0,
        FN_SET  = 2'd1,
        FN_DEL  = 2'd2,
        FN_MOVE = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [StatW-1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_RANGE  = 2'd2
    } res_stat_t;

    // configuration register indexes
    typedef enum logic [CfgAddrW-1:0] {
        CFG_X_LOWER   = 3'd0,
        CFG_X_UPPER   = 3'd1,
        CFG_X_MIN_GAP = 3'd2,
        CFG_Y_LOWER   = 3'd3,
        CFG_Y_UPPER   = 3'd4,
        CFG_MODE      = 3'd5,
        CFG_END_LOCKS = 3'd6
    } cfg_idx_t;

    // end lock bits
    localparam int LockFirstX = 0;
    localparam int LockFirstY = 1;
    localparam int LockLastX  = 2;
    localparam int LockLastY  = 3;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP,
        S_SCAN_RD, S_SCAN_CMP, S_SCAN_END,
        S_INS_CHK, S_INS_WR, S_INS_NEW,
        S_DEL_CHK, S_DEL_RD, S_DEL_CAP, S_DEL_CHK2, S_DEL_WR,
        S_MV_CHK, S_MV_RC, S_MV_RP, S_MV_RN, S_MV_NX, S_MV_LIM, S_MV_WR,
        S_MUL1, S_MUL2, S_SUM, S_ABS, S_DIV, S_DIV_END,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {RA_PTR, RA_PTR_DEC, RA_PTR_INC} rd_sel_t;
    typedef enum logic [2:0] {P_HOLD, P_ZERO, P_INC, P_DEC, P_TOTAL, P_IDX} ptr_op_t;
    typedef enum logic [2:0] {C_NONE, C_SCAN, C_CUR, C_PREV, C_NEXT} cap_t;
    typedef enum logic [1:0] {W_NONE, W_COPY, W_NEW, W_MOVE} wr_op_t;
    typedef enum logic [1:0] {T_HOLD, T_INC, T_DEC} tot_op_t;
    typedef enum logic [3:0] {
        R_NONE, R_RANGE, R_REJECT, R_EXACT, R_NEAR, R_INTERP,
        R_NEWNODE, R_DELETED, R_MOVED
    } res_op_t;
    typedef enum logic [2:0] {A_NONE, A_MUL1, A_MUL2, A_SUM, A_ABS, A_DIV} arith_t;

    // controller to datapath
    typedef struct packed {
        logic    load_in;
        rd_sel_t rd_sel;
        ptr_op_t ptr_op;
        cap_t    cap;
        wr_op_t  wr;
        tot_op_t tot;
        res_op_t res;
        arith_t  arith;
        logic    save_pos;
        logic    bounds;
        logic    out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        func_t func;
        logic  mode;
        logic  ptr_eq_total;
        logic  ptr_eq_pos;
        logic  ptr_last;
        logic  ptr_zero;
        logic  total_zero;
        logic  total_full;
        logic  hit_ge;
        logic  cur_eq_x;
        logic  idx_bad;
        logic  idx_zero;
        logic  idx_last;
        logic  lock_first;
        logic  lock_last;
        logic  div_last;
        logic  out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ design/breakpoint_envelope_table_unit.sv @@
// ----------------------------------------------------------------------------
// breakpoint_envelope_table_unit
// Piecewise-linear breakpoint table: evaluate, set, delete and move nodes
// ----------------------------------------------------------------------------
//  channel   dir  handshake                fields
//  s_*       in   s_tvalid / s_tready      func, node_index, pos_x, pos_y
//  m_*       out  m_tvalid / m_tready      status, result_index, result_x, result_y
//  cfg_*     in   cfg_we                   register index, write data
//
//  one request at a time; node memory has one write port and one registered read port
//  evaluate: scan reads and compares one node at a time; interpolation adds two
//  products, sum, magnitude and a restoring divide; set: scan as above, then shift
//  the tail up; delete: shift the tail down; move: read node and neighbours, clamp
//  the output register lets a new request in while a result still waits
//  reset empties the table; node memory itself is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_envelope_table_unit #(
    parameter int NODES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // node_index[4:0], pos_x[20:5], pos_y[36:21]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_index[4:0], result_x[20:5], result_y[36:21]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);
    import bet_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic [IdxW-1:0]   res_index;
    logic [CoordW-1:0] res_x, res_y;

    // sequencer
    bet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table and arithmetic
    bet_dpath #(
        .NODES (NODES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_func    (s_tuser),
        .in_idx     (s_tdata[4:0]),
        .in_x       (s_tdata[20:5]),
        .in_y       (s_tdata[36:21]),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_index  (res_index),
        .out_x      (res_x),
        .out_y      (res_y)
    );

    // output packing
    assign m_tdata = {3'b000, res_y, res_x, res_index};

endmodule

`default_nettype wire

@@ design/bet_ctrl.sv @@
// ----------------------------------------------------------------------------
// bet_ctrl
// Sequencer: scans, shifts, moves and divides by commanding the datapath
// ----------------------------------------------------------------------------
`default_nettype none
`include "breakpoint_envelope_table_unit_macros.svh"

module bet_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bet_pkg::sts_t sts,
    output bet_pkg::cmd_t cmd
);
    import bet_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   eval_range;
    logic   set_reject;
    logic   del_reject;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // decision terms
    assign eval_range = sts.total_zero || sts.ptr_eq_total || (sts.ptr_zero && !sts.cur_eq_x);
    assign set_reject = sts.total_full
        || (!sts.total_zero && sts.ptr_zero && !sts.cur_eq_x && sts.lock_first)
        || (!sts.total_zero && sts.ptr_eq_total && sts.lock_last);
    assign del_reject = sts.idx_bad || (sts.idx_zero && sts.lock_first)
        || (sts.idx_last && sts.lock_last);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.func)
                    FN_EVAL, FN_SET:
                    begin
                        cmd.ptr_op = P_ZERO;
                        state_next = S_SCAN_RD;
                    end
                    FN_DEL:  state_next = S_DEL_CHK;
                    FN_MOVE: state_next = S_MV_CHK;
                    default: state_next = S_IDLE;
                endcase
            end
            // linear search for the first node at or above x
            S_SCAN_RD:
            begin
                cmd.rd_sel = RA_PTR;
                state_next = sts.ptr_eq_total ? S_SCAN_END : S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                cmd.cap = C_SCAN;
                if (sts.hit_ge)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    cmd.ptr_op = P_INC;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_END:
            begin
                cmd.save_pos = 1'b1;
                if (sts.func == FN_EVAL)
                begin
                    if (eval_range)
                    begin
                        cmd.res    = R_RANGE;
                        state_next = S_OUT;
                    end
                    else if (sts.cur_eq_x)
                    begin
                        cmd.res    = R_EXACT;
                        state_next = S_OUT;
                    end
                    else if (!sts.mode)
                    begin
                        cmd.res    = R_NEAR;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MUL1;
                    end
                end
                else if (set_reject)
                begin
                    cmd.res    = R_REJECT;
                    state_next = S_OUT;
                end
                else if (!sts.ptr_eq_total && sts.cur_eq_x)
                begin
                    state_next = S_MV_RC;
                end
                else
                begin
                    cmd.ptr_op = P_TOTAL;
                    state_next = S_INS_CHK;
                end
            end
            // insert: shift the tail up one entry at a time
            S_INS_CHK:
            begin
                if (sts.ptr_eq_pos)
                begin
                    state_next = S_INS_NEW;
                end
                else
                begin
                    cmd.rd_sel = RA_PTR_DEC;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.wr     = W_COPY;
                cmd.ptr_op = P_DEC;
                state_next = S_INS_CHK;
            end
            S_INS_NEW:
            begin
                cmd.wr     = W_NEW;
                cmd.tot    = T_INC;
                cmd.res    = R_NEWNODE;
                state_next = S_OUT;
            end
            // delete: take the node, then shift the tail down
            S_DEL_CHK:
            begin
                if (del_reject)
                begin
                    cmd.res    = R_REJECT;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.ptr_op = P_IDX;
                    state_next = S_DEL_RD;
                end
            end
            S_DEL_RD:
            begin
                cmd.rd_sel = RA_PTR;
                state_next = S_DEL_CAP;
            end
            S_DEL_CAP:
            begin
                cmd.res    = R_DELETED;
                state_next = S_DEL_CHK2;
            end
            S_DEL_CHK2:
            begin
                if (sts.ptr_last)
                begin
                    cmd.tot    = T_DEC;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.rd_sel = RA_PTR_INC;
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                cmd.wr     = W_COPY;
                cmd.ptr_op = P_INC;
                state_next = S_DEL_CHK2;
            end
            // move: fetch node and neighbours, bound, clamp
            S_MV_CHK:
            begin
                if (sts.idx_bad)
                begin
                    cmd.res    = R_REJECT;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.ptr_op = P_IDX;
                    state_next = S_MV_RC;
                end
            end
            S_MV_RC:
            begin
                cmd.rd_sel = RA_PTR;
                state_next = S_MV_RP;
            end
            S_MV_RP:
            begin
                cmd.cap    = C_CUR;
                cmd.rd_sel = RA_PTR_DEC;
                state_next = S_MV_RN;
            end
            S_MV_RN:
            begin
                cmd.cap    = C_PREV;
                cmd.rd_sel = RA_PTR_INC;
                state_next = S_MV_NX;
            end
            S_MV_NX:
            begin
                cmd.cap    = C_NEXT;
                state_next = S_MV_LIM;
            end
            S_MV_LIM:
            begin
                cmd.bounds = 1'b1;
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                cmd.wr     = W_MOVE;
                cmd.res    = R_MOVED;
                state_next = S_OUT;
            end
            // interpolation: two products, sum, magnitude, divide
            S_MUL1:
            begin
                cmd.arith  = A_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.arith  = A_MUL2;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.arith  = A_SUM;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                cmd.arith  = A_ABS;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.arith = A_DIV;
                if (sts.div_last)
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                cmd.res    = R_INTERP;
                state_next = S_OUT;
            end
            // hand the result to the output register
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `BET_CHK_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != S_IDLE,
        "accepted request did not start work")
    `BET_CHK_NOW(a_out_load_free, cmd.out_load, sts.out_free,
        "result loaded over a waiting result")
    `BET_CHK_NOW(a_ready_in_idle, in_ready, state_reg == S_IDLE,
        "ready raised outside idle")

endmodule

`default_nettype wire

@@ design/bet_dpath.sv @@
// ----------------------------------------------------------------------------
// bet_dpath
// Node memory, configuration, search/shift pointers, divider and result regs
// ----------------------------------------------------------------------------
`default_nettype none
`include "breakpoint_envelope_table_unit_macros.svh"

module bet_dpath #(
    parameter int NODES = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bet_pkg::CfgAddrW-1:0]   cfg_addr,
    input  logic [bet_pkg::CfgDataW-1:0]   cfg_data,
    input  logic [bet_pkg::FuncW-1:0]      in_func,
    input  logic [bet_pkg::IdxW-1:0]       in_idx,
    input  logic [bet_pkg::CoordW-1:0]     in_x,
    input  logic [bet_pkg::CoordW-1:0]     in_y,
    input  bet_pkg::cmd_t                  cmd,
    output bet_pkg::sts_t                  sts,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bet_pkg::StatW-1:0]      out_status,
    output logic [bet_pkg::IdxW-1:0]       out_index,
    output logic [bet_pkg::CoordW-1:0]     out_x,
    output logic [bet_pkg::CoordW-1:0]     out_y
);
    import bet_pkg::*;

    localparam int AW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int KW = (CW > IdxW) ? CW : IdxW;
    localparam int EW = CoordW + 2;

    // configuration registers
    logic signed [CoordW-1:0] x_lower_reg, x_upper_reg, y_lower_reg, y_upper_reg;
    logic [GapW-1:0]          gap_reg;
    logic                     mode_reg;
    logic [LockW-1:0]         locks_reg;

    // request registers
    func_t                    func_reg;
    logic [IdxW-1:0]          idx_reg;
    logic signed [CoordW-1:0] x_reg, y_reg;

    // pointers and count
    logic [CW-1:0] total_reg, ptr_reg, pos_reg, ptr_next, ptr_inc, ptr_dec;

    // node memory
    logic [2*CoordW-1:0] mem [NODES];
    logic [2*CoordW-1:0] rd_q_reg;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic [2*CoordW-1:0] mem_wd;
    logic signed [CoordW-1:0] rd_x, rd_y;

    // captured nodes
    logic signed [CoordW-1:0] cur_x_reg, cur_y_reg, prv_x_reg, prv_y_reg;
    logic signed [CoordW-1:0] nxt_x_reg, nxt_y_reg;

    // interpolation
    logic signed [CoordW:0]     dnx, dpx;
    logic signed [2*CoordW:0]   p1_reg, p2_reg;
    logic signed [2*CoordW+1:0] num_reg;
    logic [2*CoordW+1:0]        mag;
    logic                       neg_reg;
    logic [CoordW-1:0]          dvs_reg;
    logic [DvdW-1:0]            dq_reg;
    logic [CoordW:0]            rem_reg;
    logic [CoordW+1:0]          trial;
    logic                       trial_ge;
    logic [DcntW-1:0]           dcnt_reg;
    logic signed [CoordW-1:0]   near_y, interp_y;

    // move bounds
    logic signed [EW-1:0] gap_e, lox, hix, lox_reg, hix_reg, xe;
    logic signed [CoordW-1:0] loy, hiy, loy_reg, hiy_reg;
    logic                 bnd_ok;
    logic signed [EW-1:0] clx;
    logic signed [CoordW-1:0] cly;

    // result and output registers
    logic [StatW-1:0]         res_status_reg;
    logic [IdxW-1:0]          res_index_reg;
    logic [CoordW-1:0]        res_x_reg, res_y_reg;
    logic                     out_valid_reg;
    logic [StatW-1:0]         out_status_reg;
    logic [IdxW-1:0]          out_index_reg;
    logic [CoordW-1:0]        out_x_reg, out_y_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_lower_reg <= 16'sh8000;
            x_upper_reg <= 16'sh7fff;
            gap_reg     <= '0;
            y_lower_reg <= 16'sh8000;
            y_upper_reg <= 16'sh7fff;
            mode_reg    <= 1'b1;
            locks_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_X_LOWER:   x_lower_reg <= cfg_data;
                CFG_X_UPPER:   x_upper_reg <= cfg_data;
                CFG_X_MIN_GAP: gap_reg     <= cfg_data[GapW-1:0];
                CFG_Y_LOWER:   y_lower_reg <= cfg_data;
                CFG_Y_UPPER:   y_upper_reg <= cfg_data;
                CFG_MODE:      mode_reg    <= cfg_data[0];
                CFG_END_LOCKS: locks_reg   <= cfg_data[LockW-1:0];
                default:       mode_reg    <= mode_reg;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= func_t'(in_func);
            idx_reg  <= in_idx;
            x_reg    <= in_x;
            y_reg    <= in_y;
        end
    end

    // pointer arithmetic
    assign ptr_inc = ptr_reg + CW'(1);
    assign ptr_dec = ptr_reg - CW'(1);

    always_comb
    begin
        case (cmd.ptr_op)
            P_ZERO:  ptr_next = '0;
            P_INC:   ptr_next = ptr_inc;
            P_DEC:   ptr_next = ptr_dec;
            P_TOTAL: ptr_next = total_reg;
            P_IDX:   ptr_next = CW'(idx_reg);
            default: ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            pos_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (cmd.save_pos)
            begin
                pos_reg <= ptr_reg;
            end
            case (cmd.tot)
                T_INC:   total_reg <= total_reg + CW'(1);
                T_DEC:   total_reg <= total_reg - CW'(1);
                default: total_reg <= total_reg;
            endcase
        end
    end

    // memory read address and write data
    always_comb
    begin
        case (cmd.rd_sel)
            RA_PTR_DEC: rd_addr = ptr_dec[AW-1:0];
            RA_PTR_INC: rd_addr = ptr_inc[AW-1:0];
            default:    rd_addr = ptr_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        case (cmd.wr)
            W_COPY:
            begin
                mem_we = 1'b1;
                mem_wd = rd_q_reg;
            end
            W_NEW:
            begin
                mem_we = 1'b1;
                mem_wd = {x_reg, y_reg};
            end
            W_MOVE:
            begin
                mem_we = bnd_ok;
                mem_wd = {clx[CoordW-1:0], cly};
            end
            default:
            begin
                mem_we = 1'b0;
                mem_wd = rd_q_reg;
            end
        endcase
    end

    // node memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ptr_reg[AW-1:0]] <= mem_wd;
        end
        rd_q_reg <= mem[rd_addr];
    end

    assign rd_x = rd_q_reg[2*CoordW-1:CoordW];
    assign rd_y = rd_q_reg[CoordW-1:0];

    // node capture
    always_ff @(posedge clk)
    begin
        case (cmd.cap)
            C_SCAN:
            begin
                prv_x_reg <= cur_x_reg;
                prv_y_reg <= cur_y_reg;
                cur_x_reg <= rd_x;
                cur_y_reg <= rd_y;
            end
            C_CUR:
            begin
                cur_x_reg <= rd_x;
                cur_y_reg <= rd_y;
            end
            C_PREV:
            begin
                prv_x_reg <= rd_x;
                prv_y_reg <= rd_y;
            end
            C_NEXT:
            begin
                nxt_x_reg <= rd_x;
                nxt_y_reg <= rd_y;
            end
            default:
            begin
                cur_x_reg <= cur_x_reg;
            end
        endcase
    end

    // distances to the bracketing nodes
    assign dnx    = {cur_x_reg[CoordW-1], cur_x_reg} - {x_reg[CoordW-1], x_reg};
    assign dpx    = {x_reg[CoordW-1], x_reg} - {prv_x_reg[CoordW-1], prv_x_reg};
    assign near_y = (dpx < dnx) ? prv_y_reg : cur_y_reg;

    // magnitude of the numerator and restoring divider step
    assign mag      = num_reg[2*CoordW+1] ? (2*CoordW+2)'(-num_reg)
                                          : (2*CoordW+2)'(num_reg);
    assign trial    = {rem_reg, dq_reg[DvdW-1]};
    assign trial_ge = trial >= {2'b00, dvs_reg};
    assign interp_y = neg_reg ? CoordW'(-dq_reg[CoordW:0]) : CoordW'(dq_reg[CoordW:0]);

    always_ff @(posedge clk)
    begin
        case (cmd.arith)
            A_MUL1: p1_reg <= prv_y_reg * dnx;
            A_MUL2: p2_reg <= cur_y_reg * dpx;
            A_SUM:
            begin
                num_reg <= {p1_reg[2*CoordW], p1_reg} + {p2_reg[2*CoordW], p2_reg};
                dvs_reg <= cur_x_reg - prv_x_reg;
            end
            A_ABS:
            begin
                neg_reg <= num_reg[2*CoordW+1];
            end
            A_DIV:
            begin
                rem_reg <= trial_ge ? (CoordW+1)'(trial - {2'b00, dvs_reg})
                                    : trial[CoordW:0];
                dq_reg  <= {dq_reg[DvdW-2:0], trial_ge};
            end
            default:
            begin
                p1_reg <= p1_reg;
            end
        endcase
        if (cmd.arith == A_ABS)
        begin
            dq_reg  <= DvdW'(mag) + DvdW'(dvs_reg >> 1);
            rem_reg <= '0;
        end
    end

    // divider step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.arith == A_ABS)
        begin
            dcnt_reg <= DcntW'(DivSteps);
        end
        else if (cmd.arith == A_DIV)
        begin
            dcnt_reg <= dcnt_reg - DcntW'(1);
        end
    end

    // move bounds from limits, neighbours and end locks
    assign gap_e = (gap_reg == '0) ? EW'(1) : EW'(gap_reg);
    assign xe    = EW'(x_reg);

    always_comb
    begin
        lox = EW'(x_lower_reg);
        hix = EW'(x_upper_reg);
        loy = y_lower_reg;
        hiy = y_upper_reg;
        if (sts.ptr_last)
        begin
            if (locks_reg[LockLastX])
            begin
                lox = EW'(cur_x_reg);
                hix = EW'(cur_x_reg);
            end
            if (locks_reg[LockLastY])
            begin
                loy = cur_y_reg;
                hiy = cur_y_reg;
            end
        end
        else
        begin
            hix = EW'(nxt_x_reg) - gap_e;
        end
        if (sts.ptr_zero)
        begin
            if (locks_reg[LockFirstX])
            begin
                lox = EW'(cur_x_reg);
                hix = EW'(cur_x_reg);
            end
            if (locks_reg[LockFirstY])
            begin
                loy = cur_y_reg;
                hiy = cur_y_reg;
            end
        end
        else
        begin
            lox = EW'(prv_x_reg) + gap_e;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bounds)
        begin
            lox_reg <= lox;
            hix_reg <= hix;
            loy_reg <= loy;
            hiy_reg <= hiy;
        end
    end

    // clamp into the bounds
    assign bnd_ok = lox_reg <= hix_reg;
    assign clx    = (lox_reg > xe) ? lox_reg : (hix_reg < xe) ? hix_reg : xe;
    assign cly    = (loy_reg > y_reg) ? loy_reg : (hiy_reg < y_reg) ? hiy_reg : y_reg;

    // result register
    always_ff @(posedge clk)
    begin
        case (cmd.res)
            R_RANGE:
            begin
                res_status_reg <= ST_RANGE;
                res_index_reg  <= '0;
                res_x_reg      <= x_reg;
                res_y_reg      <= '0;
            end
            R_REJECT:
            begin
                res_status_reg <= ST_REJECT;
                res_index_reg  <= idx_reg;
                res_x_reg      <= '0;
                res_y_reg      <= '0;
            end
            R_EXACT:
            begin
                res_status_reg <= ST_OK;
                res_index_reg  <= IdxW'(ptr_reg);
                res_x_reg      <= x_reg;
                res_y_reg      <= cur_y_reg;
            end
            R_NEAR:
            begin
                res_status_reg <= ST_OK;
                res_index_reg  <= IdxW'(ptr_dec);
                res_x_reg      <= x_reg;
                res_y_reg      <= near_y;
            end
            R_INTERP:
            begin
                res_status_reg <= ST_OK;
                res_index_reg  <= IdxW'(ptr_dec);
                res_x_reg      <= x_reg;
                res_y_reg      <= interp_y;
            end
            R_NEWNODE:
            begin
                res_status_reg <= ST_OK;
                res_index_reg  <= IdxW'(ptr_reg);
                res_x_reg      <= x_reg;
                res_y_reg      <= y_reg;
            end
            R_DELETED:
            begin
                res_status_reg <= ST_OK;
                res_index_reg  <= idx_reg;
                res_x_reg      <= rd_x;
                res_y_reg      <= rd_y;
            end
            R_MOVED:
            begin
                res_status_reg <= ST_OK;
                res_index_reg  <= IdxW'(ptr_reg);
                res_x_reg      <= bnd_ok ? clx[CoordW-1:0] : cur_x_reg;
                res_y_reg      <= bnd_ok ? cly : cur_y_reg;
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_index  = out_index_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;

    // status to the controller
    always_comb
    begin
        sts.func         = func_reg;
        sts.mode         = mode_reg;
        sts.ptr_eq_total = ptr_reg == total_reg;
        sts.ptr_eq_pos   = ptr_reg == pos_reg;
        sts.ptr_last     = ptr_inc == total_reg;
        sts.ptr_zero     = ptr_reg == '0;
        sts.total_zero   = total_reg == '0;
        sts.total_full   = total_reg >= CW'(NODES);
        sts.hit_ge       = rd_x >= x_reg;
        sts.cur_eq_x     = cur_x_reg == x_reg;
        sts.idx_bad      = KW'(idx_reg) >= KW'(total_reg);
        sts.idx_zero     = idx_reg == '0;
        sts.idx_last     = (KW'(idx_reg) + KW'(1)) == KW'(total_reg);
        sts.lock_first   = |locks_reg[LockFirstY:LockFirstX];
        sts.lock_last    = |locks_reg[LockLastY:LockLastX];
        sts.div_last     = dcnt_reg == DcntW'(1);
        sts.out_free     = !out_valid_reg || out_ready;
    end

    `BET_CHK_NOW(a_total_bound, 1'b1, total_reg <= CW'(NODES),
        "node count above table size")
    `BET_CHK_NOW(a_write_in_table, mem_we, ptr_reg <= total_reg,
        "write beyond the end of the table")
    `BET_CHK_NEXT(a_out_held, out_valid_reg && !out_ready,
        out_valid_reg && $stable(out_x_reg) && $stable(out_y_reg),
        "waiting result dropped or changed")

endmodule

`default_nettype wire
